[rtl/hcpg_pkg.sv]
// ----------------------------------------------------------------------------
// hcpg_pkg
// Shared widths, operation codes, controller states and register indexes of
// the Hermite curve point generator.
// ----------------------------------------------------------------------------
package hcpg_pkg;

	// Fraction bits of the curve parameter t (unsigned Q1.20).
	localparam int FRAC_BITS = 20;
	// Width of t, which reaches exactly 1.0.
	localparam int TW = FRAC_BITS + 1;
	// Width of t^2 and t^3 in Q.40; both reach exactly 1.0.
	localparam int T2W = 2 * FRAC_BITS + 1;
	// Width of the low half when a Q.40 value is split for the multiplier.
	localparam int HW = TW;
	// Multiplier operand and product widths (signed).
	localparam int MW = TW + 1;
	localparam int PW = 2 * MW;
	// Accumulator width for the weighted sum in Q.40.
	localparam int ACW = 57;
	// Configuration, coefficient, output and step counter widths.
	localparam int CW = 12;
	localparam int AW = 17;
	localparam int OW = 13;
	localparam int KW = 10;
	localparam int CFG_IW = 3;

	// Register indexes of the configuration port.
	localparam logic [CFG_IW-1:0] REG_START_X         = 3'd0;
	localparam logic [CFG_IW-1:0] REG_START_Y         = 3'd1;
	localparam logic [CFG_IW-1:0] REG_END_X           = 3'd2;
	localparam logic [CFG_IW-1:0] REG_END_Y           = 3'd3;
	localparam logic [CFG_IW-1:0] REG_START_TANGENT_X = 3'd4;
	localparam logic [CFG_IW-1:0] REG_START_TANGENT_Y = 3'd5;
	localparam logic [CFG_IW-1:0] REG_END_TANGENT_X   = 3'd6;
	localparam logic [CFG_IW-1:0] REG_END_TANGENT_Y   = 3'd7;

	// Multiplier operations issued by the controller, one per cycle.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_TSQ,
		OP_TR,
		OP_TCUBE,
		OP_BLO,
		OP_BHI,
		OP_ALO,
		OP_AHI
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TSQ,
		ST_TR,
		ST_TCUBE,
		ST_BLO,
		ST_BHI,
		ST_ALO,
		ST_AHI,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		op_t  op;
		logic finish;
	} cmd_t;

endpackage

[rtl/hcpg_mul.sv]
// ----------------------------------------------------------------------------
// hcpg_mul
// Signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module hcpg_mul (
	input  logic                          clk,
	input  logic signed [hcpg_pkg::MW-1:0] a,
	input  logic signed [hcpg_pkg::MW-1:0] b,
	output logic signed [hcpg_pkg::PW-1:0] p_s1
);
	import hcpg_pkg::*;

	always_ff @(posedge clk) begin
		p_s1 <= a * b;
	end

endmodule

[rtl/hcpg_dp.sv]
// ----------------------------------------------------------------------------
// hcpg_dp
// Datapath: configuration registers, step counter with an incremental
// divider for t, two shared multipliers and the per-coordinate accumulators.
// ----------------------------------------------------------------------------
module hcpg_dp #(
	parameter int STEPS = 1000
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [hcpg_pkg::CFG_IW-1:0]       cfg_index,
	input  logic [hcpg_pkg::CW-1:0]           cfg_data,
	input  logic                              restart,
	input  hcpg_pkg::cmd_t                    cmd,
	output logic signed [hcpg_pkg::OW-1:0]    point_x,
	output logic signed [hcpg_pkg::OW-1:0]    point_y,
	output logic                              last
);
	import hcpg_pkg::*;

	// 2^20 = STEP_Q * STEPS + STEP_R, so t advances by STEP_Q plus a carry.
	localparam logic [TW-1:0] STEP_Q = TW'((1 << FRAC_BITS) / STEPS);
	localparam logic [KW:0]   STEP_R = (KW+1)'((1 << FRAC_BITS) % STEPS);
	localparam logic [KW-1:0] HALF   = KW'(STEPS / 2);
	localparam logic [KW-1:0] K_LAST = KW'(STEPS);
	localparam logic [KW:0]   STEPS_W = (KW+1)'(STEPS);
	localparam logic [TW-1:0] T_ONE  = TW'(1 << FRAC_BITS);
	localparam int            CSW    = T2W + FRAC_BITS + 1;

	function automatic logic signed [AW-1:0] coef_a(
		input logic signed [CW-1:0] p0, input logic signed [CW-1:0] p1,
		input logic signed [CW-1:0] r0, input logic signed [CW-1:0] r1);
		logic signed [AW-1:0] d;
		d = AW'(p0) - AW'(p1);
		return (d <<< 1) + AW'(r0) + AW'(r1);
	endfunction

	function automatic logic signed [AW-1:0] coef_b(
		input logic signed [CW-1:0] p0, input logic signed [CW-1:0] p1,
		input logic signed [CW-1:0] r0, input logic signed [CW-1:0] r1);
		logic signed [AW-1:0] d;
		d = AW'(p1) - AW'(p0);
		return (d <<< 1) + d - (AW'(r0) <<< 1) - AW'(r1);
	endfunction

	// Division by 2^40 truncating toward zero.
	function automatic logic signed [OW-1:0] trunc_out(input logic signed [ACW-1:0] acc);
		logic signed [ACW-2*FRAC_BITS-1:0] q;
		q = acc[ACW-1:2*FRAC_BITS];
		if (acc[ACW-1] && (acc[2*FRAC_BITS-1:0] != '0)) begin
			q = q + 1'b1;
		end
		return q[OW-1:0];
	endfunction

	logic signed [CW-1:0] p0x_q, p0y_q, p1x_q, p1y_q, r0x_q, r0y_q, r1x_q, r1y_q;
	logic signed [AW-1:0] ax_q, ay_q, bx_q, by_q;
	logic [KW-1:0]        k_q;
	logic [TW-1:0]        tq_q;
	logic [KW-1:0]        tr_q;
	logic [KW:0]          tr_sum;
	logic [T2W-1:0]       t2_q, t3_q;
	logic [CSW-1:0]       cube_sum;
	logic signed [MW-1:0] a0, b0, a1, b1;
	logic signed [PW-1:0] prod0_s1, prod1_s1;
	op_t                  op_s1;
	logic signed [ACW-1:0] acc_x_q, acc_y_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p0x_q <= '0;
			p0y_q <= '0;
			p1x_q <= '0;
			p1y_q <= '0;
			r0x_q <= '0;
			r0y_q <= '0;
			r1x_q <= '0;
			r1y_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_START_X:         p0x_q <= cfg_data;
				REG_START_Y:         p0y_q <= cfg_data;
				REG_END_X:           p1x_q <= cfg_data;
				REG_END_Y:           p1y_q <= cfg_data;
				REG_START_TANGENT_X: r0x_q <= cfg_data;
				REG_START_TANGENT_Y: r0y_q <= cfg_data;
				REG_END_TANGENT_X:   r1x_q <= cfg_data;
				REG_END_TANGENT_Y:   r1y_q <= cfg_data;
				default:             ;
			endcase
		end
	end

	// Polynomial coefficients in the power basis, taken once per item.
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			ax_q <= coef_a(p0x_q, p1x_q, r0x_q, r1x_q);
			ay_q <= coef_a(p0y_q, p1y_q, r0y_q, r1y_q);
			bx_q <= coef_b(p0x_q, p1x_q, r0x_q, r1x_q);
			by_q <= coef_b(p0y_q, p1y_q, r0y_q, r1y_q);
		end
	end

	// Step counter with t held as quotient and remainder of the rounding divide.
	assign tr_sum = {1'b0, tr_q} + STEP_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q  <= '0;
			tq_q <= '0;
			tr_q <= HALF;
		end else if (cmd.start && restart) begin
			k_q  <= '0;
			tq_q <= '0;
			tr_q <= HALF;
		end else if (cmd.finish) begin
			if (k_q == K_LAST) begin
				k_q  <= '0;
				tq_q <= '0;
				tr_q <= HALF;
			end else begin
				k_q <= k_q + 1'b1;
				if (tr_sum >= STEPS_W) begin
					tq_q <= tq_q + STEP_Q + 1'b1;
					tr_q <= KW'(tr_sum - STEPS_W);
				end else begin
					tq_q <= tq_q + STEP_Q;
					tr_q <= tr_sum[KW-1:0];
				end
			end
		end
	end

	// Operand selection for the two multipliers (x lane and y lane).
	always_comb begin
		a0 = '0;
		b0 = '0;
		a1 = '0;
		b1 = '0;
		unique case (cmd.op)
			OP_NONE: ;
			OP_TSQ: begin
				a0 = MW'(tq_q);
				b0 = MW'(tq_q);
			end
			OP_TR: begin
				a0 = MW'(tq_q);
				b0 = MW'(r0x_q);
				a1 = MW'(tq_q);
				b1 = MW'(r0y_q);
			end
			OP_TCUBE: begin
				a0 = MW'(t2_q[HW-1:0]);
				b0 = MW'(tq_q);
				a1 = MW'(t2_q[T2W-1:HW]);
				b1 = MW'(tq_q);
			end
			OP_BLO: begin
				a0 = MW'(t2_q[HW-1:0]);
				b0 = MW'(bx_q);
				a1 = MW'(t2_q[HW-1:0]);
				b1 = MW'(by_q);
			end
			OP_BHI: begin
				a0 = MW'(t2_q[T2W-1:HW]);
				b0 = MW'(bx_q);
				a1 = MW'(t2_q[T2W-1:HW]);
				b1 = MW'(by_q);
			end
			OP_ALO: begin
				a0 = MW'(t3_q[HW-1:0]);
				b0 = MW'(ax_q);
				a1 = MW'(t3_q[HW-1:0]);
				b1 = MW'(ay_q);
			end
			OP_AHI: begin
				a0 = MW'(t3_q[T2W-1:HW]);
				b0 = MW'(ax_q);
				a1 = MW'(t3_q[T2W-1:HW]);
				b1 = MW'(ay_q);
			end
		endcase
	end

	hcpg_mul u_mul_x (
		.clk  (clk),
		.a    (a0),
		.b    (b0),
		.p_s1 (prod0_s1)
	);

	hcpg_mul u_mul_y (
		.clk  (clk),
		.a    (a1),
		.b    (b1),
		.p_s1 (prod1_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	// t^3 = (t2_hi * t * 2^21 + t2_lo * t) / 2^20, truncated.
	assign cube_sum = (CSW'($unsigned(prod1_s1)) << HW) + CSW'($unsigned(prod0_s1));

	always_ff @(posedge clk) begin
		unique case (op_s1)
			OP_NONE: ;
			OP_TSQ:  t2_q <= prod0_s1[T2W-1:0];
			OP_TR: begin
				acc_x_q <= (ACW'(p0x_q) <<< (2 * FRAC_BITS)) + (ACW'(prod0_s1) <<< FRAC_BITS);
				acc_y_q <= (ACW'(p0y_q) <<< (2 * FRAC_BITS)) + (ACW'(prod1_s1) <<< FRAC_BITS);
			end
			OP_TCUBE: t3_q <= cube_sum[FRAC_BITS +: T2W];
			OP_BLO, OP_ALO: begin
				acc_x_q <= acc_x_q + ACW'(prod0_s1);
				acc_y_q <= acc_y_q + ACW'(prod1_s1);
			end
			OP_BHI, OP_AHI: begin
				acc_x_q <= acc_x_q + (ACW'(prod0_s1) <<< HW);
				acc_y_q <= acc_y_q + (ACW'(prod1_s1) <<< HW);
			end
		endcase
	end

	// Output register; the controller only finishes when it is free.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			point_x <= trunc_out(acc_x_q);
			point_y <= trunc_out(acc_y_q);
			last    <= (k_q == K_LAST);
		end
	end

	a_k_range : assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= K_LAST)
		else $error("step counter beyond the final step");

	a_rem_range : assert property (@(posedge clk) disable iff (!arst_n)
		tr_q < STEPS_W[KW-1:0])
		else $error("divider remainder out of range");

	a_t_end : assert property (@(posedge clk) disable iff (!arst_n)
		(k_q == K_LAST) == (tq_q == T_ONE))
		else $error("t reaches one away from the final step");

endmodule

[rtl/hcpg_ctrl.sv]
// ----------------------------------------------------------------------------
// hcpg_ctrl
// Controller: sequences the multiply schedule of one point and owns the
// handshakes of the input and output streams.
// ----------------------------------------------------------------------------
module hcpg_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output hcpg_pkg::cmd_t cmd
);
	import hcpg_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd.start  = 1'b0;
		cmd.op     = OP_NONE;
		cmd.finish = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.start = 1'b1;
					state_d   = ST_TSQ;
				end
			end
			ST_TSQ: begin
				cmd.op  = OP_TSQ;
				state_d = ST_TR;
			end
			ST_TR: begin
				cmd.op  = OP_TR;
				state_d = ST_TCUBE;
			end
			ST_TCUBE: begin
				cmd.op  = OP_TCUBE;
				state_d = ST_BLO;
			end
			ST_BLO: begin
				cmd.op  = OP_BLO;
				state_d = ST_BHI;
			end
			ST_BHI: begin
				cmd.op  = OP_BHI;
				state_d = ST_ALO;
			end
			ST_ALO: begin
				cmd.op  = OP_ALO;
				state_d = ST_AHI;
			end
			ST_AHI: begin
				cmd.op  = OP_AHI;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || m_tready) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result written over a beat not yet taken");

	a_result_shown : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished point not presented");

endmodule

[rtl/hermite_curve_point_generator.sv]
// ----------------------------------------------------------------------------
// hermite_curve_point_generator
// Walks a cubic Hermite curve and gives one integer point per request beat.
// ----------------------------------------------------------------------------
// Usage:
// Program the end points and tangents through the configuration channel
// (cfg_valid/cfg_ready, cfg_index selects the register, cfg_data carries the
// 12-bit signed value). cfg_ready is always high; write only while idle.
// Each beat on the slave stream requests the next point of the curve; bit 0
// of s_tdata is the restart flag, which sends the walk back to t = 0. The
// master stream returns the point, with m_tlast set on the point at t = 1,
// after which the walk wraps back to the start on its own.
// Sequence: a request is taken in the idle state; the seven-step multiply
// schedule then runs through the two shared multipliers, followed by the
// pipeline drain and the output load, and the point then appears on the
// master side. No new request is taken while a point is being computed.
// A finished point waits in the output register while the receiver stalls,
// and the next request is accepted and computed meanwhile; only its final
// load waits for the output register to empty.
// Reset clears the configuration, idles the controller and restarts the walk.
// ----------------------------------------------------------------------------
module hermite_curve_point_generator #(
	parameter int STEPS = 1000
) (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
	// Point stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [12:0] point_x, [25:13] point_y, [31:26] zero
	output logic        m_tlast,
	// Configuration write channel.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [11:0] cfg_data
);
	import hcpg_pkg::*;

	cmd_t                 cmd;
	logic signed [OW-1:0] point_x;
	logic signed [OW-1:0] point_y;

	// Registers can always be written in a single beat.
	assign cfg_ready = 1'b1;

	hcpg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	hcpg_dp #(
		.STEPS (STEPS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.restart   (s_tdata[0]),
		.cmd       (cmd),
		.point_x   (point_x),
		.point_y   (point_y),
		.last      (m_tlast)
	);

	// Both coordinates are packed with x in the lowest bits.
	assign m_tdata = {6'b0, point_y, point_x};

endmodule
